>>> rtl/scfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_pkg
// types and constants shared by the serial command frame decoder
// ----------------------------------------------------------------------------
package scfd_pkg;

    localparam int unsigned CFG_WIDTH = 20;

    localparam logic [7:0] FRAME_MARK = 8'hFF;

    // command codes, first payload byte
    localparam logic [7:0] CMD_DRIVE  = 8'h00;
    localparam logic [7:0] CMD_SERVO  = 8'h01;
    localparam logic [7:0] CMD_SPEED  = 8'h02;
    localparam logic [7:0] CMD_LIGHT  = 8'h05;
    localparam logic [7:0] CMD_MODE   = 8'h13;
    localparam logic [7:0] CMD_SAVE   = 8'h32;
    localparam logic [7:0] CMD_RELOAD = 8'h33;
    localparam logic [7:0] CMD_FLAG   = 8'h40;

    // servo sub-codes: first four are contiguous, then two more
    localparam logic [7:0] SERVO_CODE_FIRST  = 8'd1;
    localparam logic [7:0] SERVO_CODE_SECOND = 8'd2;
    localparam logic [7:0] SERVO_CODE_THIRD  = 8'd3;
    localparam logic [7:0] SERVO_CODE_FOURTH = 8'd4;
    localparam logic [7:0] SERVO_CODE_FIFTH  = 8'd7;
    localparam logic [7:0] SERVO_CODE_SIXTH  = 8'd8;

    // light sub-codes
    localparam logic [7:0] LIGHT_SUB_ON  = 8'd0;
    localparam logic [7:0] LIGHT_SUB_OFF = 8'd1;

    // speed sub-codes
    localparam logic [7:0] SPEED_LEFT  = 8'd1;
    localparam logic [7:0] SPEED_RIGHT = 8'd2;
    localparam logic [7:0] SPEED_MAX   = 8'd10;
    localparam logic [7:0] PWM_BASE    = 8'd95;

    // servo angle limits
    localparam logic [7:0] SERVO_MAX     = 8'd170;
    localparam logic [7:0] SERVO4_MIN    = 8'd110;
    localparam logic [7:0] SERVO4_MAX    = 8'd178;
    localparam logic [2:0] SERVO4_INDEX  = 3'd3;

    // drive patterns
    localparam logic [2:0] DRIVE_STOP = 3'd0;
    localparam logic [7:0] DRIVE_LAST = 8'd4;

    // light command codes
    localparam logic [1:0] LIGHT_NONE = 2'd0;
    localparam logic [1:0] LIGHT_ON   = 2'd1;
    localparam logic [1:0] LIGHT_OFF  = 2'd2;

    // cruise modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_LINE   = 3'd2;
    localparam logic [2:0] MODE_REPORT = 3'd5;

    localparam logic [7:0] DUTY_RESET    = 8'd255;
    localparam logic [2:0] COUNT_FULL    = 3'd3;
    localparam logic [2:0] COUNT_OVER    = 3'd4;
    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 20'd100000;

    // item kinds on the input tuser
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic       pad;
        logic [7:0] flag_value;
        logic       flag_update;
        logic       reload_request;
        logic       save_request;
        logic [1:0] light_cmd;
        logic [2:0] cruise_mode;
        logic [7:0] right_pwm;
        logic [7:0] left_pwm;
        logic [7:0] servo_angle;
        logic [2:0] servo_index;
        logic       servo_update;
        logic [2:0] motor_dir;
    } t_result;

endpackage

>>> rtl/serial_command_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_decoder
// decodes 0xFF-delimited three-byte command frames from a byte/tick stream
// ----------------------------------------------------------------------------
//  channel   | dir | tdata                        | tuser
//  s_axis    | in  | rx_byte [7:0]                | func (0 byte, 1 tick)
//  m_axis    | out | result fields, see port list | -
//  cfg       | in  | timeout_ticks [19:0]         | -
//
// every input item yields exactly one result item, registered in the cycle after acceptance
// one item per cycle sustained while the output is not stalled; the only stage is the result register
// input ready drops only while a result waits and the output is stalled
// reset is synchronous, active low; it restores held outputs and idles the
// frame tracker; the config port is always ready
// ----------------------------------------------------------------------------
module serial_command_frame_decoder
    import scfd_pkg::*;
#(
    parameter int unsigned TIMER_WIDTH = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    input  logic                 s_axis_tuser,   // [0] func
    // master stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // [2:0] motor_dir, [3] servo_update,
                                                 // [6:4] servo_index, [14:7] servo_angle,
                                                 // [22:15] left_pwm, [30:23] right_pwm,
                                                 // [33:31] cruise_mode, [35:34] light_cmd,
                                                 // [36] save_request, [37] reload_request,
                                                 // [38] flag_update, [46:39] flag_value
    // config write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_WIDTH-1:0] i_cfg_data      // [19:0] timeout_ticks
);

    // frame tracker
    logic                   r_in_frame,   n_in_frame;
    logic [2:0]             r_byte_count, n_byte_count;
    logic [TIMER_WIDTH-1:0] r_timer,      n_timer;
    logic [7:0]             r_frame [3];
    logic [CFG_WIDTH-1:0]   r_timeout;

    // held outputs
    logic [2:0] r_drive, n_drive;
    logic [7:0] r_left,  n_left;
    logic [7:0] r_right, n_right;
    logic [2:0] r_mode,  n_mode;

    // result register
    logic    r_out_valid;
    t_result r_out, n_out;

    logic       accept;
    logic [7:0] cmd, sub, val;
    logic [7:0] pwm;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign cmd = r_frame[0];
    assign sub = r_frame[1];
    assign val = r_frame[2];
    // step*16 + base, step is at most ten here so it fits eight bits
    assign pwm = {val[3:0], 4'b0000} + PWM_BASE;

    always_comb begin
        n_in_frame   = r_in_frame;
        n_byte_count = r_byte_count;
        n_timer      = r_timer;
        n_drive      = r_drive;
        n_left       = r_left;
        n_right      = r_right;
        n_mode       = r_mode;
        n_out        = '0;

        if (s_axis_tuser == FUNC_TICK) begin
            if (r_in_frame) begin
                n_timer = r_timer + 1'b1;
                // timer compared at full width so a short timer never matches high bits
                if (32'(n_timer) == 32'(r_timeout)) begin
                    n_in_frame = 1'b0;
                end
            end
        end else if (!r_in_frame) begin
            if (s_axis_tdata == FRAME_MARK) begin
                n_in_frame   = 1'b1;
                n_byte_count = '0;
                n_timer      = '0;
            end
        end else if (s_axis_tdata == FRAME_MARK) begin
            n_in_frame   = 1'b0;
            n_byte_count = '0;
            if (r_byte_count == COUNT_FULL) begin
                case (cmd)
                    CMD_DRIVE: begin
                        if (sub <= DRIVE_LAST) n_drive = sub[2:0];
                    end
                    CMD_SERVO: begin
                        if (val != 8'd0) begin
                            n_out.servo_update = 1'b1;
                            case (sub)
                                SERVO_CODE_FIRST:  n_out.servo_index = 3'd0;
                                SERVO_CODE_SECOND: n_out.servo_index = 3'd1;
                                SERVO_CODE_THIRD:  n_out.servo_index = 3'd2;
                                SERVO_CODE_FOURTH: n_out.servo_index = SERVO4_INDEX;
                                SERVO_CODE_FIFTH:  n_out.servo_index = 3'd4;
                                SERVO_CODE_SIXTH:  n_out.servo_index = 3'd5;
                                default:           n_out.servo_update = 1'b0;
                            endcase
                            // fourth servo has its own window
                            if (n_out.servo_index == SERVO4_INDEX) begin
                                if (!(val inside {[SERVO4_MIN:SERVO4_MAX]}))
                                    n_out.servo_update = 1'b0;
                            end else if (val > SERVO_MAX) begin
                                n_out.servo_update = 1'b0;
                            end
                            if (n_out.servo_update) begin
                                n_out.servo_angle = val;
                            end else begin
                                n_out.servo_index = '0;
                            end
                        end
                    end
                    CMD_SPEED: begin
                        if (val <= SPEED_MAX) begin
                            if (sub == SPEED_LEFT)  n_left  = pwm;
                            if (sub == SPEED_RIGHT) n_right = pwm;
                        end
                    end
                    CMD_SAVE:   n_out.save_request   = 1'b1;
                    CMD_RELOAD: n_out.reload_request = 1'b1;
                    CMD_MODE: begin
                        // unknown sub-code falls back to normal
                        n_mode = (sub inside {[MODE_LINE:MODE_REPORT]}) ? sub[2:0]
                                                                        : MODE_NORMAL;
                    end
                    CMD_LIGHT: begin
                        if (sub == LIGHT_SUB_ON)       n_out.light_cmd = LIGHT_ON;
                        else if (sub == LIGHT_SUB_OFF) n_out.light_cmd = LIGHT_OFF;
                        else                           n_out.light_cmd = LIGHT_NONE;
                    end
                    CMD_FLAG: begin
                        n_out.flag_update = 1'b1;
                        n_out.flag_value  = sub;
                    end
                    default: ;
                endcase
            end
        end else begin
            // payload byte; count saturates so an overlong frame is dropped at close
            if (r_byte_count < COUNT_OVER) n_byte_count = r_byte_count + 1'b1;
        end

        n_out.motor_dir   = n_drive;
        n_out.left_pwm    = n_left;
        n_out.right_pwm   = n_right;
        n_out.cruise_mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_byte_count <= '0;
            r_timer      <= '0;
            r_drive      <= DRIVE_STOP;
            r_left       <= DUTY_RESET;
            r_right      <= DUTY_RESET;
            r_mode       <= MODE_NORMAL;
            r_timeout    <= TIMEOUT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_timeout <= i_cfg_data;
            if (accept) begin
                r_in_frame   <= n_in_frame;
                r_byte_count <= n_byte_count;
                r_timer      <= n_timer;
                r_drive      <= n_drive;
                r_left       <= n_left;
                r_right      <= n_right;
                r_mode       <= n_mode;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) r_out <= n_out;
        if (accept && s_axis_tuser == FUNC_BYTE && r_in_frame
                && s_axis_tdata != FRAME_MARK && r_byte_count < COUNT_FULL) begin
            r_frame[r_byte_count[1:0]] <= s_axis_tdata;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= COUNT_OVER)
        else $error("byte count past saturation");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

    a_tick_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tuser == FUNC_TICK) |=>
            (!r_out.servo_update && !r_out.flag_update && r_out.light_cmd == LIGHT_NONE))
        else $error("tick item raised a command pulse");

    a_duty_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left >= PWM_BASE) && (r_right >= PWM_BASE))
        else $error("duty below base value");

    a_held_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_out.motor_dir == r_drive && r_out.cruise_mode == r_mode))
        else $error("result disagrees with held state");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// random and directed byte/tick streams for the serial command frame decoder;
// a scoreboard tracks frames and held outputs and checks every result item
// field by field under random stalls on both stream sides
// ----------------------------------------------------------------------------
module testbench;
    import scfd_pkg::*;

    localparam int unsigned TIMER_W     = 20;
    localparam int unsigned IDLE_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int unsigned PHASE_ITEMS = 160;
    localparam int unsigned HOLD_CYCLES = 300;    // long output stall

    localparam logic [7:0] PWM_STEP = 8'd16;

    // ------------------------------------------------------------------------
    // scoreboard: frame tracker, held outputs and the queue of expected items
    // ------------------------------------------------------------------------
    class decoder_scoreboard;
        logic [CFG_WIDTH-1:0] timeout_ticks;
        logic                 in_frame;
        logic [2:0]           payload_count;
        logic [7:0]           payload [3];
        logic [TIMER_W-1:0]   tick_timer;
        logic [2:0]           drive_pattern;
        logic [7:0]           left_duty;
        logic [7:0]           right_duty;
        logic [2:0]           cruise_mode;
        t_result              expected_results [$];
        int                   mismatch_count;

        function new();
            timeout_ticks  = TIMEOUT_RESET;
            in_frame       = 1'b0;
            payload_count  = '0;
            payload        = '{default: '0};
            tick_timer     = '0;
            drive_pattern  = DRIVE_STOP;
            left_duty      = DUTY_RESET;
            right_duty     = DUTY_RESET;
            cruise_mode    = MODE_NORMAL;
            mismatch_count = 0;
        endfunction

        function void set_timeout(logic [CFG_WIDTH-1:0] ticks);
            timeout_ticks = ticks;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // apply a complete three-byte frame
        function void decode_frame(inout t_result r);
            logic [7:0] code;
            logic [7:0] sub;
            logic [7:0] val;
            int         slot;
            logic       in_range;
            code = payload[0];
            sub  = payload[1];
            val  = payload[2];
            slot = -1;
            case (code)
                CMD_DRIVE: begin
                    if (sub <= DRIVE_LAST) drive_pattern = sub[2:0];
                end
                CMD_SERVO: begin
                    if (sub >= SERVO_CODE_FIRST && sub <= SERVO_CODE_FOURTH)
                        slot = int'(sub - SERVO_CODE_FIRST);
                    else if (sub == SERVO_CODE_FIFTH)
                        slot = 4;
                    else if (sub == SERVO_CODE_SIXTH)
                        slot = 5;
                    if (slot == SERVO4_INDEX)
                        in_range = (val >= SERVO4_MIN && val <= SERVO4_MAX);
                    else
                        in_range = (val != 8'd0 && val <= SERVO_MAX);
                    if (slot >= 0 && in_range) begin
                        r.servo_update = 1'b1;
                        r.servo_index  = slot[2:0];
                        r.servo_angle  = val;
                    end
                end
                CMD_SPEED: begin
                    if (val <= SPEED_MAX) begin
                        if (sub == SPEED_LEFT)  left_duty  = val * PWM_STEP + PWM_BASE;
                        if (sub == SPEED_RIGHT) right_duty = val * PWM_STEP + PWM_BASE;
                    end
                end
                CMD_SAVE:   r.save_request   = 1'b1;
                CMD_RELOAD: r.reload_request = 1'b1;
                CMD_MODE: begin
                    cruise_mode = (sub >= MODE_LINE && sub <= MODE_REPORT) ? sub[2:0]
                                                                           : MODE_NORMAL;
                end
                CMD_LIGHT: begin
                    if (sub == LIGHT_SUB_ON)       r.light_cmd = LIGHT_ON;
                    else if (sub == LIGHT_SUB_OFF) r.light_cmd = LIGHT_OFF;
                end
                CMD_FLAG: begin
                    r.flag_update = 1'b1;
                    r.flag_value  = sub;
                end
                default: ;
            endcase
        endfunction

        // one accepted input item, one expected result item
        function void note_item(logic func, logic [7:0] rx_byte);
            t_result r;
            r = '0;
            if (func == FUNC_TICK) begin
                if (in_frame) begin
                    tick_timer = tick_timer + 1'b1;
                    if (tick_timer == timeout_ticks) in_frame = 1'b0;
                end
            end else if (!in_frame) begin
                if (rx_byte == FRAME_MARK) begin
                    in_frame      = 1'b1;
                    payload_count = '0;
                    tick_timer    = '0;
                end
            end else if (rx_byte == FRAME_MARK) begin
                in_frame = 1'b0;
                if (payload_count == COUNT_FULL) decode_frame(r);
                payload_count = '0;
            end else begin
                if (payload_count < COUNT_FULL) payload[payload_count] = rx_byte;
                if (payload_count < COUNT_OVER) payload_count = payload_count + 1'b1;
            end
            r.motor_dir   = drive_pattern;
            r.left_pwm    = left_duty;
            r.right_pwm   = right_duty;
            r.cruise_mode = cruise_mode;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch on %s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result item with nothing expected: %h", got);
                return;
            end
            want = expected_results.pop_front();
            compare_field("motor_dir",      want.motor_dir,      got.motor_dir);
            compare_field("servo_update",   want.servo_update,   got.servo_update);
            compare_field("servo_index",    want.servo_index,    got.servo_index);
            compare_field("servo_angle",    want.servo_angle,    got.servo_angle);
            compare_field("left_pwm",       want.left_pwm,       got.left_pwm);
            compare_field("right_pwm",      want.right_pwm,      got.right_pwm);
            compare_field("cruise_mode",    want.cruise_mode,    got.cruise_mode);
            compare_field("light_cmd",      want.light_cmd,      got.light_cmd);
            compare_field("save_request",   want.save_request,   got.save_request);
            compare_field("reload_request", want.reload_request, got.reload_request);
            compare_field("flag_update",    want.flag_update,    got.flag_update);
            compare_field("flag_value",     want.flag_value,     got.flag_value);
            compare_field("pad",            want.pad,            got.pad);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [7:0] rx_byte
    logic                 s_axis_tuser  = 1'b0; // [0] func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;         // t_result, motor_dir in the lowest bits
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_WIDTH-1:0] i_cfg_data    = '0;   // [19:0] timeout_ticks

    decoder_scoreboard sb;

    int tx_calm     = 0;    // items left in a no-gap stretch, sender
    int rx_calm     = 0;    // items left in a no-stall stretch, receiver
    int tick_odds   = 1;    // chance in ten of ticks between frame bytes
    int items_sent  = 0;
    int idle_cycles = 0;

    // interesting values for the third payload byte
    logic [7:0] value_marks [12] = '{8'd0, 8'd1, SPEED_MAX, SPEED_MAX + 8'd1,
                                     SERVO4_MIN - 8'd1, SERVO4_MIN, SERVO_MAX,
                                     SERVO_MAX + 8'd1, SERVO4_MAX, SERVO4_MAX + 8'd1,
                                     8'd128, 8'd254};

    logic [7:0] command_codes [8] = '{CMD_DRIVE, CMD_SERVO, CMD_SPEED, CMD_LIGHT,
                                      CMD_MODE, CMD_RELOAD, CMD_SAVE, CMD_FLAG};

    // directed opening: {func, byte}
    logic [8:0] directed_items [27] = '{
        // tick while idle, carrying the marker byte; stray byte while idle
        {FUNC_TICK, FRAME_MARK}, {FUNC_BYTE, 8'h00},
        // drive forward
        {FUNC_BYTE, FRAME_MARK}, {FUNC_BYTE, CMD_DRIVE}, {FUNC_BYTE, 8'h01},
        {FUNC_BYTE, 8'h00}, {FUNC_BYTE, FRAME_MARK},
        // fourth servo at its upper limit
        {FUNC_BYTE, FRAME_MARK}, {FUNC_BYTE, CMD_SERVO}, {FUNC_BYTE, SERVO_CODE_FOURTH},
        {FUNC_BYTE, SERVO4_MAX}, {FUNC_BYTE, FRAME_MARK},
        // left speed at the top step
        {FUNC_BYTE, FRAME_MARK}, {FUNC_BYTE, CMD_SPEED}, {FUNC_BYTE, SPEED_LEFT},
        {FUNC_BYTE, SPEED_MAX}, {FUNC_BYTE, FRAME_MARK},
        // short frame, dropped
        {FUNC_BYTE, FRAME_MARK}, {FUNC_BYTE, CMD_LIGHT}, {FUNC_BYTE, LIGHT_SUB_ON},
        {FUNC_BYTE, FRAME_MARK},
        // frame with an extra byte, dropped
        {FUNC_BYTE, FRAME_MARK}, {FUNC_BYTE, CMD_FLAG}, {FUNC_BYTE, 8'hFE},
        {FUNC_BYTE, 8'h80}, {FUNC_BYTE, 8'h7F}, {FUNC_BYTE, FRAME_MARK}
    };

    serial_command_frame_decoder #(
        .TIMER_WIDTH (TIMER_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // wait before the next item: random, with runs of back-to-back items
    function automatic int draw_gap(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // offer one input item and wait for its handshake; valid stays high after
    task automatic send_item(logic func, logic [7:0] rx_byte);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_byte;
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(func, rx_byte);
        items_sent++;
    endtask

    // sometimes a few ticks, so open frames age and may time out
    task automatic send_ticks();
        if ($urandom_range(0, 9) < tick_odds)
            repeat ($urandom_range(1, 3))
                send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
    endtask

    // mostly well-formed frames with random content, the rest broken or noise
    task automatic send_random_frame();
        int         kind;
        int         len;
        logic [7:0] code;
        logic [7:0] sub;
        logic [7:0] val;
        logic [7:0] body [$];
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            // line noise: any byte, markers included, and ticks
            repeat ($urandom_range(1, 4))
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            return;
        end
        if (kind < 70) begin
            code = ($urandom_range(0, 8) == 0) ? 8'($urandom_range(0, 254))
                                               : command_codes[$urandom_range(0, 7)];
            sub  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 254))
                                               : 8'($urandom_range(0, 9));
            case ($urandom_range(0, 3))
                0:       val = 8'($urandom_range(0, 254));
                1:       val = 8'($urandom_range(0, 12));
                2:       val = value_marks[$urandom_range(0, 11)];
                default: val = 8'($urandom_range(100, 190));
            endcase
            body = '{code, sub, val};
        end else begin
            // too short or too long, dropped on close
            len = (kind < 80) ? $urandom_range(0, 2) : $urandom_range(4, 6);
            repeat (len) body.push_back(8'($urandom_range(0, 254)));
        end
        send_item(FUNC_BYTE, FRAME_MARK);
        foreach (body[i]) begin
            send_ticks();
            send_item(FUNC_BYTE, body[i]);
        end
        send_ticks();
        send_item(FUNC_BYTE, FRAME_MARK);
    endtask

    // stop offering, let every expected item arrive, then settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // config write while the block is idle
    task automatic write_timeout(logic [CFG_WIDTH-1:0] ticks);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_timeout(ticks);
    endtask

    // ------------------------------------------------------------------------
    // stimulus: reset, directed opening, then phases at several timeouts
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase_start;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_items[i])
            send_item(directed_items[i][8], directed_items[i][7:0]);

        for (int p = 0; p < 5; p++) begin
            // first phase runs at the reset timeout
            if (p > 0) begin
                drain_results();
                case (p)
                    1:       write_timeout(CFG_WIDTH'(1));
                    2:       write_timeout(CFG_WIDTH'($urandom_range(2, 6)));
                    3:       write_timeout({CFG_WIDTH{1'b1}});
                    default: write_timeout(CFG_WIDTH'($urandom_range(3, 60)));
                endcase
            end
            tick_odds   = $urandom_range(1, 4);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_random_frame();
        end

        drain_results();
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("PASS serial_command_frame_decoder");
        else
            $display("FAIL serial_command_frame_decoder");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random stalls, plus long hold-offs that back up the input
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_gap(rx_calm);
            if (taken == 250 || taken == 600) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    // check each accepted result; watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL serial_command_frame_decoder");
            $finish;
        end
    end

endmodule
